// ----- sv/rpfb_pkg.sv -----
// ----------------------------------------------------------------------------
// rpfb_pkg
// Types and codes shared by the page frame buffer plotter and its checker.
// ----------------------------------------------------------------------------
package rpfb_pkg;

   localparam int ADDR_W = 14;

   typedef enum logic [1:0] {
      REQ_PLOT  = 2'd0,
      REQ_CLEAR = 2'd1,
      REQ_READ  = 2'd2,
      REQ_NONE  = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1,
      CSR_ORIENT = 2'd2,
      CSR_UNUSED = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_MAP,
      ST_PLOT_RD,
      ST_PLOT_WR,
      ST_READ_WAIT,
      ST_CLEAR
   } state_type;

   typedef struct packed {
      req_code_type req_type;
      logic [7:0]   pos_x;
      logic [7:0]   pos_y;
      logic         pixel_on;
      logic [9:0]   byte_index;
   } req_word_type;

   typedef struct packed {
      logic       status;
      logic [7:0] read_data;
   } rsp_word_type;

   typedef struct packed {
      logic              miss;
      logic [ADDR_W-1:0] addr;
      logic [2:0]        bit_sel;
   } map_type;

endpackage

// ----- sv/rpfb_map.sv -----
// ----------------------------------------------------------------------------
// rpfb_map
// Rotates a logical point onto the panel, checks it against the active
// geometry and forms the byte address and bit position in page layout.
// ----------------------------------------------------------------------------
module rpfb_map (
   input  logic [7:0]       width_use,
   input  logic [6:0]       height_use,
   input  logic             rotated,
   input  logic [7:0]       pos_x,
   input  logic [7:0]       pos_y,
   output rpfb_pkg::map_type map_out
);
   import rpfb_pkg::*;

   logic [7:0] hx;
   logic [7:0] hy;
   logic       miss;

   always_comb begin
      if (rotated) begin
         miss = (pos_x >= {1'b0, height_use}) || (pos_y >= width_use);
         hx   = width_use - 8'd1 - pos_y;
         hy   = pos_x;
      end else begin
         miss = (pos_x >= width_use) || (pos_y >= {1'b0, height_use});
         hx   = pos_x;
         hy   = pos_y;
      end
      map_out.miss    = miss;
      map_out.addr    = ADDR_W'(hy[7:3]) * ADDR_W'(width_use) + ADDR_W'(hx);
      map_out.bit_sel = hy[2:0];
   end

endmodule

// ----- sv/rotating_page_framebuffer_plotter.sv -----
// ----------------------------------------------------------------------------
// rotating_page_framebuffer_plotter
// One-bit-per-pixel frame buffer in vertical-page layout with plot, clear
// and byte read requests and a rotatable coordinate system.
//
//   channel  ports                         handshake
//   req      start, busy, req_word         accepted when start && !busy
//   rsp      rsp_strobe, rsp_word          one-cycle strobe, no back-pressure
//   csr      csr_valid, csr_ready, csr_*   written when valid && ready
//
// A plot maps the point, reads the memory byte and writes the byte back
// before its response word. A read is bounded by the registered memory
// read port. A clear sweeps the store one byte a cycle and answers once
// the last byte is written. After reset the same sweep runs over every
// byte with busy high; configuration writes are taken throughout. The
// response side never stalls the block.
// ----------------------------------------------------------------------------
module rotating_page_framebuffer_plotter #(
   parameter int BUF_BYTES  = 1024,
   parameter int MAX_WIDTH  = 128,
   parameter int MAX_HEIGHT = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  rpfb_pkg::req_word_type req_word,
   output logic                   rsp_strobe,
   output rpfb_pkg::rsp_word_type rsp_word,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [7:0]             csr_data
);
   import rpfb_pkg::*;

   localparam int AW = $clog2(BUF_BYTES);

   logic [7:0]    mem [BUF_BYTES];
   logic [7:0]    rd_data_ff;

   state_type     state_ff, state_in;
   req_word_type  req_ff, req_in;
   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic [AW-1:0] plot_addr_ff, plot_addr_in;
   logic [2:0]    plot_bit_ff, plot_bit_in;
   logic          rd_ok_ff, rd_ok_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_word_type  rsp_ff, rsp_in;

   logic [7:0]    panel_width_ff;
   logic [6:0]    panel_height_ff;
   logic [1:0]    orientation_ff;

   logic [7:0]    width_use;
   logic [6:0]    height_use;
   map_type       map_res;
   logic          accept;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic [AW-1:0] rd_addr;
   logic [7:0]    bit_mask;

   assign width_use  = (panel_width_ff > 8'(MAX_WIDTH)) ? 8'(MAX_WIDTH) : panel_width_ff;
   assign height_use = (panel_height_ff > 7'(MAX_HEIGHT)) ? 7'(MAX_HEIGHT) : panel_height_ff;

   rpfb_map u_map (
      .width_use  (width_use),
      .height_use (height_use),
      .rotated    (orientation_ff[0]),
      .pos_x      (req_ff.pos_x),
      .pos_y      (req_ff.pos_y),
      .map_out    (map_res)
   );

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         panel_width_ff  <= 8'd128;
         panel_height_ff <= 7'd64;
         orientation_ff  <= 2'd0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_WIDTH:  panel_width_ff  <= csr_data;
            CSR_HEIGHT: panel_height_ff <= csr_data[6:0];
            CSR_ORIENT: orientation_ff  <= csr_data[1:0];
            default: begin
            end
         endcase
      end
   end

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign bit_mask = 8'd1 << plot_bit_ff;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      clr_cnt_in   = clr_cnt_ff;
      plot_addr_in = plot_addr_ff;
      plot_bit_in  = plot_bit_ff;
      rd_ok_in     = rd_ok_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      wr_en        = 1'b0;
      wr_addr      = clr_cnt_ff;
      wr_data      = 8'h00;
      rd_addr      = plot_addr_ff;
      unique case (state_ff)
         ST_INIT: begin
            wr_en      = 1'b1;
            clr_cnt_in = clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == AW'(BUF_BYTES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            rd_addr = req_word.byte_index[AW-1:0];
            if (accept) begin
               req_in     = req_word;
               rd_ok_in   = (11'(req_word.byte_index) < 11'(BUF_BYTES));
               clr_cnt_in = '0;
               unique case (req_word.req_type)
                  REQ_PLOT:  state_in = ST_MAP;
                  REQ_CLEAR: state_in = ST_CLEAR;
                  REQ_READ:  state_in = ST_READ_WAIT;
                  default:   rsp_valid_in = 1'b1;
               endcase
            end
         end
         ST_MAP: begin
            plot_addr_in = map_res.addr[AW-1:0];
            plot_bit_in  = map_res.bit_sel;
            if (map_res.miss || (map_res.addr >= ADDR_W'(BUF_BYTES))) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               state_in = ST_PLOT_RD;
            end
         end
         ST_PLOT_RD: begin
            state_in = ST_PLOT_WR;
         end
         ST_PLOT_WR: begin
            wr_en        = 1'b1;
            wr_addr      = plot_addr_ff;
            wr_data      = req_ff.pixel_on ? (rd_data_ff | bit_mask) : (rd_data_ff & ~bit_mask);
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_READ_WAIT: begin
            rsp_valid_in     = 1'b1;
            rsp_in.read_data = rd_ok_ff ? rd_data_ff : 8'h00;
            state_in         = ST_IDLE;
         end
         ST_CLEAR: begin
            wr_en      = 1'b1;
            clr_cnt_in = clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == AW'(BUF_BYTES - 1)) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      plot_addr_ff <= plot_addr_in;
      plot_bit_ff  <= plot_bit_in;
      rd_ok_ff     <= rd_ok_in;
      rsp_ff       <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_word   = rsp_ff;

endmodule

// ----- sv/rpfb_checker.sv -----
// ----------------------------------------------------------------------------
// rpfb_checker
// Port-level checks on the request and response channels of the plotter.
// ----------------------------------------------------------------------------
module rpfb_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input rpfb_pkg::req_word_type req_word,
   input logic                   rsp_strobe,
   input rpfb_pkg::rsp_word_type rsp_word
);
   import rpfb_pkg::*;

   logic accept;

   assign accept = start && !busy;

   a_read_latency: assert property (@(posedge clock) disable iff (reset)
      accept && req_word.req_type == REQ_READ |=> ##1 (rsp_strobe && !rsp_word.status))
      else $error("read word did not answer two cycles after accept");

   a_none_answer: assert property (@(posedge clock) disable iff (reset)
      accept && req_word.req_type == REQ_NONE |=> rsp_strobe && rsp_word == '0)
      else $error("unused request code did not answer with a zero word");

   a_busy_after: assert property (@(posedge clock) disable iff (reset)
      accept && req_word.req_type != REQ_NONE |=> busy && !rsp_strobe)
      else $error("block not busy after accepting a request word");

   a_data_status: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_word.read_data != 8'h00 |-> !rsp_word.status)
      else $error("response word carries data and a failure status");

endmodule

bind rotating_page_framebuffer_plotter rpfb_checker u_rpfb_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_word   (req_word),
   .rsp_strobe (rsp_strobe),
   .rsp_word   (rsp_word)
);
